// ===== rtl/core/cfd_pkg.sv =====
package cfd_pkg;

  localparam int CFG_IDX_W = 3;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_PEER_OP   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CHAT_OP   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_BCAST_OP  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_OP_LIMIT  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_TEXT_MAX  = 3'd4;

  localparam logic [31:0] PEER_OP_RST  = 32'd1;
  localparam logic [31:0] CHAT_OP_RST  = 32'd2;
  localparam logic [31:0] BCAST_OP_RST = 32'd3;
  localparam logic [31:0] OP_LIMIT_RST = 32'd16;
  localparam logic [15:0] TEXT_MAX_RST = 16'd1024;

  typedef enum logic [2:0] {
    KIND_HEADER = 3'd0,
    KIND_NICK   = 3'd1,
    KIND_ADDR   = 3'd2,
    KIND_PORT   = 3'd3,
    KIND_KEY    = 3'd4,
    KIND_CHAT   = 3'd5,
    KIND_BCAST  = 3'd6,
    KIND_SKIP   = 3'd7
  } kind_e;

  typedef enum logic [2:0] {
    PH_IDLE   = 3'b001,
    PH_HEADER = 3'b010,
    PH_BODY   = 3'b100
  } phase_e;

  typedef struct packed {
    logic [31:0] peer_op;
    logic [31:0] chat_op;
    logic [31:0] bcast_op;
    logic [31:0] op_limit;
    logic [15:0] text_max;
  } cfg_t;

  typedef struct packed {
    kind_e       kind;
    logic [31:0] value;
    logic [31:0] frame_length;
    logic [31:0] entry_index;
    logic [31:0] position;
    logic        legal;
    logic        error;
    logic        last;
  } result_t;

endpackage

// ===== rtl/core/cfd_cfg_regs.sv =====
module cfd_cfg_regs (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          wr_en_i,
  input  logic [cfd_pkg::CFG_IDX_W-1:0] wr_index_i,
  input  logic [31:0]                   wr_data_i,
  output cfd_pkg::cfg_t                 cfg_o
);

  cfd_pkg::cfg_t cfg_q;

  // indexes past the register list are dropped
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.peer_op  <= cfd_pkg::PEER_OP_RST;
      cfg_q.chat_op  <= cfd_pkg::CHAT_OP_RST;
      cfg_q.bcast_op <= cfd_pkg::BCAST_OP_RST;
      cfg_q.op_limit <= cfd_pkg::OP_LIMIT_RST;
      cfg_q.text_max <= cfd_pkg::TEXT_MAX_RST;
    end else if (wr_en_i) begin
      case (wr_index_i)
        cfd_pkg::REG_PEER_OP:  cfg_q.peer_op  <= wr_data_i;
        cfd_pkg::REG_CHAT_OP:  cfg_q.chat_op  <= wr_data_i;
        cfd_pkg::REG_BCAST_OP: cfg_q.bcast_op <= wr_data_i;
        cfd_pkg::REG_OP_LIMIT: cfg_q.op_limit <= wr_data_i;
        cfd_pkg::REG_TEXT_MAX: cfg_q.text_max <= wr_data_i[15:0];
        default: ;
      endcase
    end
  end

  assign cfg_o = cfg_q;

endmodule

// ===== rtl/core/cfd_parser.sv =====
module cfd_parser #(
  parameter int OPCODE_BYTES = 4,
  parameter int HEADER_BYTES = 8,
  parameter int NICK_BYTES   = 16,
  parameter int ADDR_BYTES   = 4,
  parameter int PORT_BYTES   = 2,
  parameter int KEY_BYTES    = 16
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             accept_i,
  input  logic [7:0]       byte_i,
  input  cfd_pkg::cfg_t    cfg_i,
  output logic             res_valid_o,
  output cfd_pkg::result_t res_o
);

  localparam int ENTRY_BYTES = NICK_BYTES + ADDR_BYTES + PORT_BYTES + KEY_BYTES;
  localparam int RW          = $clog2(ENTRY_BYTES);
  localparam int ADDR_LO     = NICK_BYTES;
  localparam int ADDR_HI     = NICK_BYTES + ADDR_BYTES - 1;
  localparam int PORT_LO     = NICK_BYTES + ADDR_BYTES;
  localparam int PORT_HI     = PORT_LO + PORT_BYTES - 1;
  localparam int KEY_LO      = PORT_LO + PORT_BYTES;

  cfd_pkg::phase_e phase_q, phase_d;
  logic [31:0]     opcode_q, opcode_d;
  logic [31:0]     length_q, length_d;
  logic [31:0]     off_q, off_d;
  logic [31:0]     addr_q, addr_d;
  logic [15:0]     port_q, port_d;
  logic [RW-1:0]   r_q, r_d;
  logic [31:0]     entry_q, entry_d;
  logic [32:0]     entry_end_q, entry_end_d;

  logic            is_body, hdr_done, body_last, text_last, msg_last;
  logic            is_peer, is_chat, is_bcast, trailing, r_wrap;
  logic            in_addr, in_port, emit;
  logic [31:0]     op_new, len_new, addr_new;
  logic [15:0]     port_new, text_lim;
  logic [32:0]     off_inc;
  cfd_pkg::result_t res;

  assign is_body  = (phase_q == cfd_pkg::PH_BODY);
  assign off_inc  = {1'b0, off_q} + 33'd1;
  assign hdr_done = (off_q == 32'(HEADER_BYTES - 1));
  assign body_last = (off_inc >= {1'b0, length_q});
  assign text_lim  = (cfg_i.text_max == 16'd0) ? 16'd1 : cfg_i.text_max;
  assign text_last = (off_inc >= {17'd0, text_lim});
  assign is_peer  = (opcode_q == cfg_i.peer_op);
  assign is_chat  = (opcode_q == cfg_i.chat_op);
  assign is_bcast = (opcode_q == cfg_i.bcast_op);
  // entry is trailing when its end runs past the body
  assign trailing = (entry_end_q > {1'b0, length_q});
  assign r_wrap   = (r_q == RW'(ENTRY_BYTES - 1));
  assign in_addr  = (r_q >= RW'(ADDR_LO)) && (r_q <= RW'(ADDR_HI));
  assign in_port  = (r_q >= RW'(PORT_LO)) && (r_q <= RW'(PORT_HI));
  assign addr_new = (r_q == RW'(ADDR_LO)) ? {24'd0, byte_i} : {addr_q[23:0], byte_i};
  assign port_new = (r_q == RW'(PORT_LO)) ? {8'd0, byte_i} : {port_q[7:0], byte_i};

  always_comb begin
    op_new  = opcode_q;
    len_new = length_q;
    if (off_q < 32'(OPCODE_BYTES)) begin
      op_new = {opcode_q[23:0], byte_i};
    end else begin
      len_new = {length_q[23:0], byte_i};
    end
  end

  always_comb begin
    emit             = 1'b0;
    msg_last         = body_last;
    res.kind         = cfd_pkg::KIND_HEADER;
    res.value        = 32'd0;
    res.frame_length = 32'd0;
    res.entry_index  = 32'd0;
    res.position     = 32'd0;
    res.legal        = 1'b0;
    res.error        = 1'b0;
    res.last         = 1'b0;
    if (!is_body) begin
      emit             = hdr_done;
      res.value        = op_new;
      res.frame_length = len_new;
      res.legal        = (op_new < cfg_i.op_limit);
      res.last         = (len_new == 32'd0);
    end else begin
      res.value = {24'd0, byte_i};
      emit      = 1'b1;
      if (is_peer) begin
        res.entry_index = entry_q;
        if (trailing) begin
          res.kind     = cfd_pkg::KIND_SKIP;
          res.position = 32'(r_q);
          res.error    = 1'b1;
        end else if (r_q < RW'(NICK_BYTES)) begin
          res.kind     = cfd_pkg::KIND_NICK;
          res.position = 32'(r_q);
        end else if (in_addr) begin
          res.kind  = cfd_pkg::KIND_ADDR;
          res.value = addr_new;
          emit      = (r_q == RW'(ADDR_HI));
        end else if (in_port) begin
          res.kind  = cfd_pkg::KIND_PORT;
          res.value = {16'd0, port_new};
          emit      = (r_q == RW'(PORT_HI));
        end else begin
          res.kind     = cfd_pkg::KIND_KEY;
          res.position = 32'(r_q - RW'(KEY_LO));
        end
      end else if (is_chat || is_bcast) begin
        res.kind     = is_chat ? cfd_pkg::KIND_CHAT : cfd_pkg::KIND_BCAST;
        res.position = off_q;
        msg_last     = body_last || text_last;
      end else begin
        res.kind     = cfd_pkg::KIND_SKIP;
        res.position = off_q;
        res.error    = 1'b1;
      end
      res.last = msg_last;
    end
  end

  always_comb begin
    phase_d     = phase_q;
    opcode_d    = opcode_q;
    length_d    = length_q;
    off_d       = off_q;
    addr_d      = addr_q;
    port_d      = port_q;
    r_d         = r_q;
    entry_d     = entry_q;
    entry_end_d = entry_end_q;
    if (accept_i) begin
      if (!is_body) begin
        phase_d  = cfd_pkg::PH_HEADER;
        opcode_d = op_new;
        length_d = len_new;
        off_d    = off_q + 32'd1;
        if (hdr_done) begin
          if (len_new == 32'd0) begin
            phase_d  = cfd_pkg::PH_IDLE;
            opcode_d = 32'd0;
            length_d = 32'd0;
            off_d    = 32'd0;
          end else begin
            phase_d     = cfd_pkg::PH_BODY;
            off_d       = 32'd0;
            r_d         = '0;
            entry_d     = 32'd0;
            entry_end_d = 33'(ENTRY_BYTES);
          end
        end
      end else begin
        if (is_peer && !trailing && in_addr) addr_d = addr_new;
        if (is_peer && !trailing && in_port) port_d = port_new;
        if (msg_last) begin
          phase_d  = cfd_pkg::PH_IDLE;
          opcode_d = 32'd0;
          length_d = 32'd0;
          off_d    = 32'd0;
        end else begin
          off_d = off_q + 32'd1;
          if (r_wrap) begin
            r_d         = '0;
            entry_d     = entry_q + 32'd1;
            entry_end_d = entry_end_q + 33'(ENTRY_BYTES);
          end else begin
            r_d = r_q + RW'(1);
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= cfd_pkg::PH_IDLE;
      opcode_q    <= 32'd0;
      length_q    <= 32'd0;
      off_q       <= 32'd0;
      addr_q      <= 32'd0;
      port_q      <= 16'd0;
      r_q         <= '0;
      entry_q     <= 32'd0;
      entry_end_q <= 33'(ENTRY_BYTES);
    end else begin
      phase_q     <= phase_d;
      opcode_q    <= opcode_d;
      length_q    <= length_d;
      off_q       <= off_d;
      addr_q      <= addr_d;
      port_q      <= port_d;
      r_q         <= r_d;
      entry_q     <= entry_d;
      entry_end_q <= entry_end_d;
    end
  end

  assign res_valid_o = accept_i && emit;
  assign res_o       = res;

  a_body_len_nonzero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == cfd_pkg::PH_BODY) |-> (length_q != 32'd0))
    else $error("body phase with zero length");

  a_entry_pos_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(r_q) < 32'(ENTRY_BYTES))
    else $error("entry byte position out of range");

  a_header_off_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q != cfd_pkg::PH_BODY) |-> (off_q < 32'(HEADER_BYTES)))
    else $error("header offset past header");

  a_header_done_result : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept_i && !is_body && hdr_done) |-> (res_valid_o && res.kind == cfd_pkg::KIND_HEADER))
    else $error("header completion gave no header word");

endmodule

// ===== rtl/core/cfd_out_buf.sv =====
module cfd_out_buf (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  cfd_pkg::result_t data_i,
  output logic             ready_o,
  output logic             valid_o,
  input  logic             pop_ready_i,
  output cfd_pkg::result_t data_o
);

  logic             valid_q, valid_d;
  logic             skid_q, skid_d;
  cfd_pkg::result_t main_q, main_d;
  cfd_pkg::result_t spare_q, spare_d;
  logic             pop;

  assign pop     = valid_q && pop_ready_i;
  assign ready_o = !skid_q;

  always_comb begin
    valid_d = valid_q;
    skid_d  = skid_q;
    main_d  = main_q;
    spare_d = spare_q;
    if (pop || !valid_q) begin
      // advance: skid word moves up first, keeping order
      valid_d = skid_q || push_i;
      main_d  = skid_q ? spare_q : data_i;
      skid_d  = skid_q && push_i;
      spare_d = data_i;
    end else if (push_i) begin
      // hold the output word, park the new one
      skid_d  = 1'b1;
      spare_d = data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      skid_q  <= 1'b0;
    end else begin
      valid_q <= valid_d;
      skid_q  <= skid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    main_q  <= main_d;
    spare_q <= spare_d;
  end

  assign valid_o = valid_q;
  assign data_o  = main_q;

  a_skid_implies_main : assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_q |-> valid_q)
    else $error("skid word without output word");

  a_no_push_full : assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> !skid_q)
    else $error("word pushed into full buffer");

  a_skid_held : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (skid_q && !pop) |=> (skid_q && $stable(spare_q)))
    else $error("parked word lost while stalled");

endmodule

// ===== rtl/core/chat_frame_deframer_top.sv =====
// Channel  Handshake                  Payload
// in       in_valid_i / in_ready_o    byte_in_i
// out      out_valid_o / out_ready_i  kind_o value_o frame_length_o entry_index_o
//                                     position_o legal_o error_o last_o
// cfg      cfg_valid_i / cfg_ready_o  cfg_index_i cfg_data_i
//
// One byte per cycle while in_ready_o is high; results are registered in the output buffer.
// A two-word output buffer holds results; in_ready_o drops only while both are full.
// Reset clears the parse state and loads the register defaults; cfg is always ready.
// Address and port bytes of a complete entry give one word, on the last byte of their field.
module chat_frame_deframer_top #(
  parameter int OPCODE_BYTES = 4,
  parameter int HEADER_BYTES = 8,
  parameter int NICK_BYTES   = 16,
  parameter int ADDR_BYTES   = 4,
  parameter int PORT_BYTES   = 2,
  parameter int KEY_BYTES    = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [7:0]                    byte_in_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [2:0]                    kind_o,
  output logic [31:0]                   value_o,
  output logic [31:0]                   frame_length_o,
  output logic [31:0]                   entry_index_o,
  output logic [31:0]                   position_o,
  output logic                          legal_o,
  output logic                          error_o,
  output logic                          last_o,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [cfd_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [31:0]                   cfg_data_i
);

  cfd_pkg::cfg_t    cfg;
  cfd_pkg::result_t res, out_word;
  logic             res_valid, accept, buf_ready;

  assign cfg_ready_o = 1'b1;
  assign in_ready_o  = buf_ready;
  assign accept      = in_valid_i && buf_ready;

  cfd_cfg_regs u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_en_i    (cfg_valid_i),
    .wr_index_i (cfg_index_i),
    .wr_data_i  (cfg_data_i),
    .cfg_o      (cfg)
  );

  cfd_parser #(
    .OPCODE_BYTES (OPCODE_BYTES),
    .HEADER_BYTES (HEADER_BYTES),
    .NICK_BYTES   (NICK_BYTES),
    .ADDR_BYTES   (ADDR_BYTES),
    .PORT_BYTES   (PORT_BYTES),
    .KEY_BYTES    (KEY_BYTES)
  ) u_parser (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (accept),
    .byte_i      (byte_in_i),
    .cfg_i       (cfg),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  cfd_out_buf u_out_buf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (res_valid),
    .data_i      (res),
    .ready_o     (buf_ready),
    .valid_o     (out_valid_o),
    .pop_ready_i (out_ready_i),
    .data_o      (out_word)
  );

  assign kind_o         = out_word.kind;
  assign value_o        = out_word.value;
  assign frame_length_o = out_word.frame_length;
  assign entry_index_o  = out_word.entry_index;
  assign position_o     = out_word.position;
  assign legal_o        = out_word.legal;
  assign error_o        = out_word.error;
  assign last_o         = out_word.last;

endmodule
